// File: design/slice_block_budget_allocator_macros.svh
// assertion macros for the slice block budget allocator
// used by the top level only; no other dependency
`ifndef SLICE_BLOCK_BUDGET_ALLOCATOR_MACROS_SVH
`define SLICE_BLOCK_BUDGET_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define SBBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbba check failed");
`define SBBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbba check failed");
`else
`define SBBA_ASSERT_IMP(lbl, ante, cons)
`define SBBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/sbba_pkg.sv
// shared types, constants and functions of the slice block budget allocator
// no dependencies
package sbba_pkg;

  localparam int MAX_SLICES = 8;
  localparam int IDX_W      = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int CNT_W      = $clog2(MAX_SLICES + 1);

  localparam int PCT_W      = 7;
  localparam int BLK_W      = 9;
  localparam int CAP_W      = 10;
  localparam int SUM_W      = 15;
  localparam int PROD_W     = 16;
  localparam int OUT_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 23;
  localparam int QPROD_W     = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(83887);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  localparam logic [BLK_W-1:0] TOTAL_RESET = BLK_W'(275);
  localparam logic [CAP_W-1:0] CAP_RESET   = '1;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_CAP = CFG_IDX_W'(1);

  // steps of one slice during emission
  localparam logic [2:0] STEP_DED    = 3'd0;
  localparam logic [2:0] STEP_MIN    = 3'd1;
  localparam logic [2:0] STEP_MAX    = 3'd2;
  localparam logic [2:0] STEP_OTHERS = 3'd3;
  localparam logic [2:0] STEP_CEIL   = 3'd4;
  localparam logic [2:0] STEP_OUT    = 3'd5;
  localparam logic [2:0] DRAIN_LAST  = 3'd1;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SUM   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    SEL_DED = 2'd0,
    SEL_MIN = 2'd1,
    SEL_MAX = 2'd2
  } pct_sel_e;

  typedef struct packed {
    logic             load_item;
    logic [IDX_W-1:0] wr_idx;
    logic             start;
    logic [IDX_W-1:0] rd_idx;
    pct_sel_e         sel;
    logic             issue_acc;
    logic             lat_ded;
    logic             lat_min;
    logic             lat_ceil;
    logic             out_load;
    logic             out_final;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

  // floor(x / 100) by reciprocal, exact for every 16-bit product used here
  function automatic logic [BLK_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [QPROD_W-1:0] p;
    p = QPROD_W'(x) * QPROD_W'(RECIP);
    return p[RECIP_SHIFT +: BLK_W];
  endfunction

endpackage

// File: design/sbba_if.sv
// item, result and configuration channels of the slice block budget allocator
// depends on sbba_pkg
interface sbba_in_if import sbba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             slice_present;
  logic [PCT_W-1:0] dedicated_pct;
  logic [PCT_W-1:0] minimum_pct;
  logic [PCT_W-1:0] maximum_pct;
  logic             last_slice;

  modport source (
    output valid, slice_present, dedicated_pct, minimum_pct, maximum_pct, last_slice,
    input  ready
  );
  modport sink (
    input  valid, slice_present, dedicated_pct, minimum_pct, maximum_pct, last_slice,
    output ready
  );
endinterface

interface sbba_out_if import sbba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] slice_index;
  logic                 valid_slice;
  logic [BLK_W-1:0]     dedicated_blocks;
  logic [BLK_W-1:0]     minimum_blocks;
  logic [BLK_W-1:0]     ceiling_blocks;
  logic                 final_result;

  modport source (
    output valid, slice_index, valid_slice, dedicated_blocks, minimum_blocks,
           ceiling_blocks, final_result,
    input  ready
  );
  modport sink (
    input  valid, slice_index, valid_slice, dedicated_blocks, minimum_blocks,
           ceiling_blocks, final_result,
    output ready
  );
endinterface

interface sbba_cfg_if import sbba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/slice_block_budget_allocator.sv
// Slice block budget allocator. Slice policies are taken one item per cycle
// and stored (up to MAX_SLICES per run). The item that carries last_slice starts
// the emission: the input is held off while the shared multiply/divide-by-100
// unit first sums the slices' minimum budgets and then works out each slice's
// budgets one slice after another, waiting whenever the result channel stalls.
// The last item always starts the emission, even when the store is already full.
// Configuration is taken every cycle. Depends on sbba_pkg, sbba_if, sbba_ctrl,
// sbba_dp and the assertion macros header.
`include "slice_block_budget_allocator_macros.svh"

module slice_block_budget_allocator import sbba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbba_cfg_if.sink   cfg_i,
  sbba_in_if.sink    in_i,
  sbba_out_if.source out_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_i.ready = in_ready;

  sbba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_slice),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sbba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .slice_present_i (in_i.slice_present),
    .dedicated_pct_i (in_i.dedicated_pct),
    .minimum_pct_i   (in_i.minimum_pct),
    .maximum_pct_i   (in_i.maximum_pct),
    .cfg_i           (cfg_i),
    .out_o           (out_o)
  );

  `SBBA_ASSERT_IMP(a_store_only_when_open, cmd.load_item, in_ready)
  `SBBA_ASSERT_IMP(a_no_load_while_emitting, cmd.out_load, !in_ready)
  `SBBA_ASSERT_IMP(a_result_slot_free, cmd.out_load, stat.out_free)
  `SBBA_ASSERT_NXT(a_reopen_after_final, cmd.out_load && cmd.out_final, in_ready && out_o.valid)

endmodule

// File: design/sbba_ctrl.sv
// controller: load counter, emission walk and step sequencing
// depends on sbba_pkg
module sbba_ctrl import sbba_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [2:0]       sub_q, sub_d;
  logic [CNT_W-1:0] cnt_inc;
  logic             room;
  logic             last_idx;

  assign room     = count_q < CNT_W'(MAX_SLICES);
  assign cnt_inc  = room ? count_q + CNT_W'(1) : count_q;
  assign last_idx = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    sub_d      = sub_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = SEL_MIN;
    cmd_o.rd_idx = idx_q;
    cmd_o.wr_idx = count_q[IDX_W-1:0];
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = room;
          count_d = cnt_inc;
          if (in_last_i && (cnt_inc != '0)) begin
            cmd_o.start = 1'b1;
            idx_d   = '0;
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sel       = SEL_MIN;
        cmd_o.issue_acc = 1'b1;
        if (last_idx) begin
          sub_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        sub_d = sub_q + 3'd1;
        if (sub_q == DRAIN_LAST) begin
          sub_d   = STEP_DED;
          idx_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        sub_d = sub_q + 3'd1;
        case (sub_q)
          STEP_DED: cmd_o.sel = SEL_DED;
          STEP_MIN: cmd_o.sel = SEL_MIN;
          STEP_MAX: begin
            cmd_o.sel     = SEL_MAX;
            cmd_o.lat_ded = 1'b1;
          end
          STEP_OTHERS: cmd_o.lat_min = 1'b1;
          STEP_CEIL:   cmd_o.lat_ceil = 1'b1;
          STEP_OUT: begin
            sub_d = sub_q;
            if (stat_i.out_free) begin
              cmd_o.out_load  = 1'b1;
              cmd_o.out_final = last_idx;
              sub_d = STEP_DED;
              if (last_idx) begin
                count_d = '0;
                state_d = ST_LOAD;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
          end
          default: sub_d = STEP_DED;
        endcase
      end
      default: begin
        count_d = '0;
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      idx_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
    end
  end

endmodule

// File: design/sbba_dp.sv
// datapath: configuration registers, slice store, share unit and result register
// depends on sbba_pkg and the channel interfaces in sbba_if
module sbba_dp import sbba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic             slice_present_i,
  input  logic [PCT_W-1:0] dedicated_pct_i,
  input  logic [PCT_W-1:0] minimum_pct_i,
  input  logic [PCT_W-1:0] maximum_pct_i,
  sbba_cfg_if.sink         cfg_i,
  sbba_out_if.source       out_o
);

  logic [BLK_W-1:0]        total_cfg_q;
  logic signed [CAP_W-1:0] ext_cap_q;
  logic [BLK_W-1:0]        usable_total;
  logic [BLK_W-1:0]        total_q;

  logic             pres_q   [MAX_SLICES];
  logic [PCT_W-1:0] ded_st_q [MAX_SLICES];
  logic [PCT_W-1:0] min_st_q [MAX_SLICES];
  logic [PCT_W-1:0] max_st_q [MAX_SLICES];

  logic             rd_pres;
  logic [PCT_W-1:0] pct_sel;
  logic [PCT_W-1:0] pct_eff;

  logic [PROD_W-1:0] prod_q;
  logic [BLK_W-1:0]  share_q;
  logic              tag1_q, tag2_q;
  logic [SUM_W-1:0]  sum_q;
  logic [BLK_W-1:0]  ded_q, mn_q, ceil_q;
  logic [SUM_W-1:0]  others_q;
  logic [BLK_W-1:0]  ceil_base, ceil_d;

  logic                 out_valid_q;
  logic [OUT_IDX_W-1:0] idx_out_q;
  logic                 vs_out_q, fin_out_q;
  logic [BLK_W-1:0]     ded_out_q, min_out_q, ceil_out_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_cfg_q <= TOTAL_RESET;
      ext_cap_q   <= CAP_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TOTAL_BLOCKS: total_cfg_q <= cfg_i.data[BLK_W-1:0];
        REG_EXTERNAL_CAP: ext_cap_q   <= cfg_i.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign usable_total = (!ext_cap_q[CAP_W-1] && (total_cfg_q > ext_cap_q[BLK_W-1:0]))
                      ? ext_cap_q[BLK_W-1:0] : total_cfg_q;

  // slice store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pres_q[cmd_i.wr_idx]   <= slice_present_i;
      ded_st_q[cmd_i.wr_idx] <= sat_pct(dedicated_pct_i);
      min_st_q[cmd_i.wr_idx] <= sat_pct(minimum_pct_i);
      max_st_q[cmd_i.wr_idx] <= sat_pct(maximum_pct_i);
    end
    if (cmd_i.start) begin
      total_q <= usable_total;
    end
  end

  assign rd_pres = pres_q[cmd_i.rd_idx];

  always_comb begin
    case (cmd_i.sel)
      SEL_DED: pct_sel = ded_st_q[cmd_i.rd_idx];
      SEL_MIN: pct_sel = min_st_q[cmd_i.rd_idx];
      SEL_MAX: pct_sel = max_st_q[cmd_i.rd_idx];
      default: pct_sel = '0;
    endcase
  end

  assign pct_eff = rd_pres ? pct_sel : '0;

  // share unit: multiply, then divide by 100
  always_ff @(posedge clk_i) begin
    prod_q  <= PROD_W'(total_q) * PROD_W'(pct_eff);
    share_q <= div100(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= 1'b0;
      tag2_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      tag1_q <= cmd_i.issue_acc;
      tag2_q <= tag1_q;
      if (cmd_i.start) begin
        sum_q <= '0;
      end else if (tag2_q) begin
        sum_q <= sum_q + SUM_W'(share_q);
      end
    end
  end

  // ceiling
  assign ceil_base = (SUM_W'(total_q) > others_q)
                   ? total_q - others_q[BLK_W-1:0] : '0;
  assign ceil_d    = ((share_q != '0) && (share_q < ceil_base)) ? share_q : ceil_base;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_ded) begin
      ded_q <= share_q;
    end
    if (cmd_i.lat_min) begin
      mn_q     <= share_q;
      others_q <= sum_q - SUM_W'(share_q);
    end
    if (cmd_i.lat_ceil) begin
      ceil_q <= ceil_d;
    end
  end

  // result register
  assign stat_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      idx_out_q  <= OUT_IDX_W'(cmd_i.rd_idx);
      vs_out_q   <= rd_pres;
      ded_out_q  <= rd_pres ? ded_q : '0;
      min_out_q  <= rd_pres ? mn_q : '0;
      ceil_out_q <= rd_pres ? ceil_q : '0;
      fin_out_q  <= cmd_i.out_final;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.slice_index      = idx_out_q;
  assign out_o.valid_slice      = vs_out_q;
  assign out_o.dedicated_blocks = ded_out_q;
  assign out_o.minimum_blocks   = min_out_q;
  assign out_o.ceiling_blocks   = ceil_out_q;
  assign out_o.final_result     = fin_out_q;

endmodule
